[hw/rtl/qmb_pkg.sv]
// Package for the queued mailbox: command and status codes, field widths and
// the controller-to-datapath command struct. No dependencies.
package qmb_pkg;

  localparam int CMD_W    = 2;
  localparam int TAG_W    = 8;
  localparam int PAY_W    = 56;
  localparam int REC_W    = TAG_W + PAY_W;
  localparam int WORD_W   = 32;
  localparam int SEQ_W    = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_PUMP = 2'd1,
    CMD_RECV = 2'd2,
    CMD_NONE = 2'd3
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_BUSY    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NOTHING = 3'd4
  } status_code_t;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming command fields
    logic exec;  // carry out the captured command and load the result
  } ctrl_cmd_t;

endpackage

[hw/rtl/qmb_if.sv]
// Valid/ready channel interfaces for the command and result streams.
// Depends on qmb_pkg for field widths.
interface qmb_in_if;
  logic                           valid;
  logic                           ready;
  logic [qmb_pkg::CMD_W-1:0]      command;
  logic [qmb_pkg::TAG_W-1:0]      record_tag;
  logic [qmb_pkg::PAY_W-1:0]      record_payload;

  modport source (output valid, command, record_tag, record_payload, input ready);
  modport sink   (input valid, command, record_tag, record_payload, output ready);
endinterface

interface qmb_out_if;
  logic                           valid;
  logic                           ready;
  logic [qmb_pkg::STATUS_W-1:0]   status;
  logic [qmb_pkg::WORD_W-1:0]     mailbox_word_low;
  logic [qmb_pkg::WORD_W-1:0]     mailbox_word_high;
  logic [qmb_pkg::SEQ_W-1:0]      sequence_res;
  logic                           doorbell;
  logic [qmb_pkg::TAG_W-1:0]      received_tag;
  logic [qmb_pkg::PAY_W-1:0]      received_payload;

  modport source (output valid, status, mailbox_word_low, mailbox_word_high, sequence_res,
                  doorbell, received_tag, received_payload, input ready);
  modport sink   (input valid, status, mailbox_word_low, mailbox_word_high, sequence_res,
                  doorbell, received_tag, received_payload, output ready);
endinterface

[hw/rtl/qmb_ctrl.sv]
// Controller state machine for the queued mailbox: sequences capture,
// execution and result transfer. Depends on qmb_pkg.
module qmb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output qmb_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/qmb_dp.sv]
// Datapath of the queued mailbox: record ring memory, ring indexes, sequence
// counters, mailbox slot and result registers. Depends on qmb_pkg.
module qmb_dp #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qmb_pkg::ctrl_cmd_t             cmd,
  input  logic [qmb_pkg::CMD_W-1:0]      command,
  input  logic [qmb_pkg::TAG_W-1:0]      record_tag,
  input  logic [qmb_pkg::PAY_W-1:0]      record_payload,
  output logic [qmb_pkg::STATUS_W-1:0]   status,
  output logic [qmb_pkg::WORD_W-1:0]     mailbox_word_low,
  output logic [qmb_pkg::WORD_W-1:0]     mailbox_word_high,
  output logic [qmb_pkg::SEQ_W-1:0]      sequence_res,
  output logic                           doorbell,
  output logic [qmb_pkg::TAG_W-1:0]      received_tag,
  output logic [qmb_pkg::PAY_W-1:0]      received_payload
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

  // Ring storage; entries are only read after they were written.
  logic [qmb_pkg::REC_W-1:0] mem [FIFO_DEPTH];
  logic [qmb_pkg::REC_W-1:0] rd_data;

  // Captured command.
  logic [qmb_pkg::CMD_W-1:0] cmd_q;
  logic [qmb_pkg::TAG_W-1:0] tag_q;
  logic [qmb_pkg::PAY_W-1:0] pay_q;

  // Control state. The mailbox sequence always equals the publish count and
  // the acknowledge always equals the seen sequence, so one register each.
  logic [AW-1:0]              wr_idx, wr_idx_next;
  logic [AW-1:0]              rd_idx, rd_idx_next;
  logic [qmb_pkg::SEQ_W-1:0]  pub_seq, pub_seq_next;
  logic [qmb_pkg::SEQ_W-1:0]  seen_seq, seen_seq_next;
  logic [qmb_pkg::REC_W-1:0]  mbox, mbox_next;

  logic                       mem_we;
  logic [AW-1:0]              wr_succ;
  logic [AW-1:0]              rd_succ;
  logic [qmb_pkg::STATUS_W-1:0] status_next;
  logic [qmb_pkg::WORD_W-1:0] word_low_next;
  logic [qmb_pkg::WORD_W-1:0] word_high_next;
  logic [qmb_pkg::SEQ_W-1:0]  seq_res_next;
  logic                       doorbell_next;
  logic [qmb_pkg::TAG_W-1:0]  rtag_next;
  logic [qmb_pkg::PAY_W-1:0]  rpay_next;

  assign wr_succ = (wr_idx == LAST_IDX) ? '0 : wr_idx + AW'(1);
  assign rd_succ = (rd_idx == LAST_IDX) ? '0 : rd_idx + AW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= {pay_q, tag_q};
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      tag_q <= record_tag;
      pay_q <= record_payload;
    end
  end

  always_comb begin
    mem_we         = 1'b0;
    wr_idx_next    = wr_idx;
    rd_idx_next    = rd_idx;
    pub_seq_next   = pub_seq;
    seen_seq_next  = seen_seq;
    mbox_next      = mbox;
    status_next    = qmb_pkg::ST_NOTHING;
    word_low_next  = '0;
    word_high_next = '0;
    seq_res_next   = '0;
    doorbell_next  = 1'b0;
    rtag_next      = '0;
    rpay_next      = '0;
    unique case (cmd_q)
      qmb_pkg::CMD_PUSH: begin
        if (wr_succ == rd_idx) begin
          status_next = qmb_pkg::ST_FULL;
        end else begin
          mem_we      = cmd.exec;
          wr_idx_next = wr_succ;
          status_next = qmb_pkg::ST_DONE;
        end
      end
      qmb_pkg::CMD_PUMP: begin
        if (seen_seq != pub_seq) begin
          status_next = qmb_pkg::ST_BUSY;
        end else if (rd_idx == wr_idx) begin
          status_next = qmb_pkg::ST_EMPTY;
        end else begin
          rd_idx_next    = rd_succ;
          mbox_next      = rd_data;
          pub_seq_next   = pub_seq + qmb_pkg::SEQ_W'(1);
          status_next    = qmb_pkg::ST_DONE;
          word_low_next  = rd_data[qmb_pkg::WORD_W-1:0];
          word_high_next = rd_data[qmb_pkg::REC_W-1:qmb_pkg::WORD_W];
          seq_res_next   = pub_seq_next;
          doorbell_next  = 1'b1;
        end
      end
      qmb_pkg::CMD_RECV: begin
        if (pub_seq == seen_seq) begin
          status_next = qmb_pkg::ST_NOTHING;
        end else begin
          seen_seq_next = pub_seq;
          status_next   = qmb_pkg::ST_DONE;
          seq_res_next  = pub_seq;
          rtag_next     = mbox[qmb_pkg::TAG_W-1:0];
          rpay_next     = mbox[qmb_pkg::REC_W-1:qmb_pkg::TAG_W];
        end
      end
      default: begin
        status_next = qmb_pkg::ST_NOTHING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx   <= '0;
      rd_idx   <= '0;
      pub_seq  <= '0;
      seen_seq <= '0;
      mbox     <= '0;
    end else if (cmd.exec) begin
      wr_idx   <= wr_idx_next;
      rd_idx   <= rd_idx_next;
      pub_seq  <= pub_seq_next;
      seen_seq <= seen_seq_next;
      mbox     <= mbox_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status            <= status_next;
      mailbox_word_low  <= word_low_next;
      mailbox_word_high <= word_high_next;
      sequence_res      <= seq_res_next;
      doorbell          <= doorbell_next;
      received_tag      <= rtag_next;
      received_payload  <= rpay_next;
    end
  end

endmodule

[hw/rtl/queued_mailbox_seq_ack.sv]
// Queued mailbox with sequence acknowledge: every command transfer yields one
// result transfer. After a command is accepted, the capture/execute/respond
// controller executes it in its execute state and then offers the result in
// its respond state until it is taken; one command is in flight at a time.
// Reset (synchronous, rst high) empties the ring and clears all sequences and
// the mailbox slot; the ring memory itself is not cleared.
module queued_mailbox_seq_ack #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  qmb_in_if.sink    cmd_ch,
  qmb_out_if.source res_ch
);

  // Controller strobes toward the datapath.
  qmb_pkg::ctrl_cmd_t ctrl_cmd;

  // The controller owns the handshakes: it accepts a command only when idle,
  // executes it in its execute state, then holds the result until its transfer.
  qmb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_ch.valid),
    .in_ready  (cmd_ch.ready),
    .out_valid (res_ch.valid),
    .out_ready (res_ch.ready),
    .cmd       (ctrl_cmd)
  );

  // The datapath holds the ring memory, ring indexes, the publish and seen
  // sequences and the mailbox slot. Its result registers load during the
  // execute cycle and stay stable while the result waits.
  qmb_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (ctrl_cmd),
    .command           (cmd_ch.command),
    .record_tag        (cmd_ch.record_tag),
    .record_payload    (cmd_ch.record_payload),
    .status            (res_ch.status),
    .mailbox_word_low  (res_ch.mailbox_word_low),
    .mailbox_word_high (res_ch.mailbox_word_high),
    .sequence_res      (res_ch.sequence_res),
    .doorbell          (res_ch.doorbell),
    .received_tag      (res_ch.received_tag),
    .received_payload  (res_ch.received_payload)
  );

`ifndef SYNTH
  // The block never takes a command while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ch.ready && res_ch.valid))
    else $error("command ready while a result is pending");

  // A command transfer is always followed by a result offer after the execute state.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (cmd_ch.valid && cmd_ch.ready) |-> ##2 res_ch.valid)
    else $error("result not offered two cycles after command transfer");

  // A doorbell only accompanies a successful pump.
  a_doorbell: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.doorbell) |-> (res_ch.status == qmb_pkg::ST_DONE))
    else $error("doorbell with a failure status");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for queued_mailbox_seq_ack: directed and random command
// traffic with a built-in mailbox predictor. Depends on qmb_pkg, qmb_if and the RTL.
module tb;

  localparam int DEPTH       = 256;
  localparam int AW          = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 12;

  // One expected or observed result transfer, field for field.
  typedef struct packed {
    qmb_pkg::status_code_t        status;
    logic [qmb_pkg::WORD_W-1:0]   word_low;
    logic [qmb_pkg::WORD_W-1:0]   word_high;
    logic [qmb_pkg::SEQ_W-1:0]    seq;
    logic                         doorbell;
    logic [qmb_pkg::TAG_W-1:0]    rx_tag;
    logic [qmb_pkg::PAY_W-1:0]    rx_payload;
  } mailbox_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic res_ready = 1'b0;

  qmb_in_if  cmd_if ();
  qmb_out_if res_if ();

  assign res_if.ready = res_ready;

  queued_mailbox_seq_ack #(
    .FIFO_DEPTH(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .cmd_ch(cmd_if),
    .res_ch(res_if)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state. The ring contents are only read at slots that a push
  // wrote earlier, so they need no initial value.
  logic [qmb_pkg::REC_W-1:0] ring_mem [DEPTH];
  int                        wr_idx = 0;
  int                        rd_idx = 0;
  logic [qmb_pkg::SEQ_W-1:0] pub_count = '0;
  logic [qmb_pkg::SEQ_W-1:0] mbox_seq = '0;
  logic [qmb_pkg::SEQ_W-1:0] ack_seq = '0;
  logic [qmb_pkg::SEQ_W-1:0] seen_seq = '0;
  logic [qmb_pkg::REC_W-1:0] mbox_data = '0;

  mailbox_result_t pending_results [$];
  int              mismatch_count = 0;
  int              result_count = 0;
  int              cycle_count = 0;

  // Sender pacing: items go out in bursts, with random idle gaps in between
  // whenever gaps are switched on.
  int burst_left = 0;
  bit gaps_on = 1'b0;

  function automatic int ring_next(input int idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int ring_fill();
    return (wr_idx - rd_idx + DEPTH) % DEPTH;
  endfunction

  // Advances the predicted mailbox by one command and returns what the block
  // should answer. Fields that do not apply to the outcome stay zero.
  task automatic mailbox_step(input qmb_pkg::cmd_code_t cmd,
                              input logic [qmb_pkg::TAG_W-1:0] tag,
                              input logic [qmb_pkg::PAY_W-1:0] payload,
                              output mailbox_result_t res);
    logic [qmb_pkg::REC_W-1:0] rec;
    logic [31:0]               wr_pos;
    logic [31:0]               rd_pos;
    res = '0;
    wr_pos = wr_idx;
    rd_pos = rd_idx;
    case (cmd)
      qmb_pkg::CMD_PUSH: begin
        if (ring_next(wr_idx) == rd_idx) begin
          res.status = qmb_pkg::ST_FULL;
        end else begin
          ring_mem[wr_pos[AW-1:0]] = {payload, tag};
          wr_idx = ring_next(wr_idx);
          res.status = qmb_pkg::ST_DONE;
        end
      end
      qmb_pkg::CMD_PUMP: begin
        // The busy check wins over the empty check.
        if (ack_seq != pub_count) begin
          res.status = qmb_pkg::ST_BUSY;
        end else if (rd_idx == wr_idx) begin
          res.status = qmb_pkg::ST_EMPTY;
        end else begin
          rec = ring_mem[rd_pos[AW-1:0]];
          rd_idx = ring_next(rd_idx);
          mbox_data = rec;
          pub_count = pub_count + 1'b1;
          mbox_seq = pub_count;
          res.status = qmb_pkg::ST_DONE;
          res.word_low = rec[qmb_pkg::WORD_W-1:0];
          res.word_high = rec[qmb_pkg::REC_W-1:qmb_pkg::WORD_W];
          res.seq = pub_count;
          res.doorbell = 1'b1;
        end
      end
      qmb_pkg::CMD_RECV: begin
        if (mbox_seq == seen_seq) begin
          res.status = qmb_pkg::ST_NOTHING;
        end else begin
          seen_seq = mbox_seq;
          ack_seq = mbox_seq;
          res.status = qmb_pkg::ST_DONE;
          res.seq = mbox_seq;
          res.rx_tag = mbox_data[qmb_pkg::TAG_W-1:0];
          res.rx_payload = mbox_data[qmb_pkg::REC_W-1:qmb_pkg::TAG_W];
        end
      end
      default: res.status = qmb_pkg::ST_NOTHING;
    endcase
  endtask

  // Sends one command transfer. Inputs change on the falling edge; the
  // transfer happens at the first rising edge that sees ready high. Valid
  // stays high from one item to the next inside a burst.
  task automatic send_cmd(input qmb_pkg::cmd_code_t cmd,
                          input logic [qmb_pkg::TAG_W-1:0] tag,
                          input logic [qmb_pkg::PAY_W-1:0] payload,
                          output qmb_pkg::status_code_t st);
    mailbox_result_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(0, 6);
        repeat (gap) begin
          @(negedge clk);
          cmd_if.valid = 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    cmd_if.valid = 1'b1;
    cmd_if.command = cmd;
    cmd_if.record_tag = tag;
    cmd_if.record_payload = payload;
    do @(posedge clk); while (!cmd_if.ready);
    mailbox_step(cmd, tag, payload, res);
    pending_results.push_back(res);
    st = res.status;
  endtask

  function automatic logic [qmb_pkg::PAY_W-1:0] rand_payload();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[qmb_pkg::PAY_W-1:0];
  endfunction

  function automatic logic [qmb_pkg::TAG_W-1:0] rand_tag();
    logic [31:0] r;
    r = $urandom;
    return r[qmb_pkg::TAG_W-1:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d %s: got %h, expected %h", result_count, field, got, want);
    mismatch_count++;
  endtask

  // Checks every result transfer against the oldest expectation.
  always @(posedge clk) begin
    mailbox_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", 64'(res_if.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", 64'(res_if.status), 64'(want.status));
        if (res_if.mailbox_word_low !== want.word_low)
          report_mismatch("mailbox_word_low", 64'(res_if.mailbox_word_low),
                          64'(want.word_low));
        if (res_if.mailbox_word_high !== want.word_high)
          report_mismatch("mailbox_word_high", 64'(res_if.mailbox_word_high),
                          64'(want.word_high));
        if (res_if.sequence_res !== want.seq)
          report_mismatch("sequence_res", 64'(res_if.sequence_res), 64'(want.seq));
        if (res_if.doorbell !== want.doorbell)
          report_mismatch("doorbell", 64'(res_if.doorbell), 64'(want.doorbell));
        if (res_if.received_tag !== want.rx_tag)
          report_mismatch("received_tag", 64'(res_if.received_tag), 64'(want.rx_tag));
        if (res_if.received_payload !== want.rx_payload)
          report_mismatch("received_payload", 64'(res_if.received_payload),
                          64'(want.rx_payload));
      end
      result_count++;
    end
  end

  // Result-side backpressure. The mode is drawn anew each time the phase counter
  // wraps: always ready, a rotating stall pattern, or sparse random acceptance.
  // The pattern always keeps one bit set, so the rotating mode never stalls for good.
  int          rx_mode = 0;
  int          rx_phase = 0;
  logic [15:0] rx_pattern = 16'hffff;

  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_pattern = 16'($urandom) | 16'h0001;
    end
    rx_phase = (rx_phase + 1) % 64;
    rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
    case (rx_mode)
      0:       res_ready <= 1'b1;
      1:       res_ready <= rx_pattern[0];
      default: res_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("queued_mailbox_seq_ack: mismatch");
      $finish;
    end
  end

  // Commands that find nothing to do straight after reset: a receive with no
  // new sequence, a pump on an empty ring, and the unused command code with
  // every input bit set and with every input bit clear.
  task automatic test_idle_commands();
    qmb_pkg::status_code_t st;
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_NONE, '1, '1, st);
    send_cmd(qmb_pkg::CMD_NONE, '0, '0, st);
  endtask

  // Field extremes through the whole path: push, publish, and receive, with
  // the busy and nothing-new refusals in between.
  task automatic test_record_path();
    qmb_pkg::status_code_t st;
    send_cmd(qmb_pkg::CMD_PUSH, 8'h00, 56'h0, st);
    send_cmd(qmb_pkg::CMD_PUSH, 8'hff, '1, st);
    send_cmd(qmb_pkg::CMD_PUSH, 8'ha5, 56'h0123456789abcd, st);
    send_cmd(qmb_pkg::CMD_PUSH, 8'h5a, 56'hfedcba98765432, st);
    send_cmd(qmb_pkg::CMD_PUMP, '1, '1, st);
    // Not yet acknowledged, so a second pump must be refused as busy.
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_NONE, 8'h3c, 56'h00ff00ff00ff00, st);
    send_cmd(qmb_pkg::CMD_RECV, '1, '1, st);
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
    // The ring is drained and the mailbox acknowledged: empty.
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
  endtask

  // Fills the ring to its last usable slot, checks that further pushes are
  // refused as full, then frees one slot and fills it again.
  task automatic test_ring_full();
    qmb_pkg::status_code_t st;
    gaps_on = 1'b1;
    while (ring_fill() < DEPTH - 1)
      send_cmd(qmb_pkg::CMD_PUSH, rand_tag(), rand_payload(), st);
    send_cmd(qmb_pkg::CMD_PUSH, rand_tag(), rand_payload(), st);
    send_cmd(qmb_pkg::CMD_PUSH, '1, '1, st);
    send_cmd(qmb_pkg::CMD_PUMP, '0, '0, st);
    send_cmd(qmb_pkg::CMD_RECV, '0, '0, st);
    send_cmd(qmb_pkg::CMD_PUSH, rand_tag(), rand_payload(), st);
    send_cmd(qmb_pkg::CMD_PUSH, rand_tag(), rand_payload(), st);
  endtask

  // Random traffic. Most of it is well-formed producer/consumer sequences
  // with random records; push bursts and drains are chosen by ring fill so
  // that the ring swings between nearly empty and busy levels. The rest is
  // noise: any command code with random fields, which also produces broken
  // sequences such as a pump without a receive. Only completed commands count.
  task automatic test_random_traffic(input int done_target);
    qmb_pkg::status_code_t st;
    int done_count;
    int pick;
    int burst;
    done_count = 0;
    while (done_count < done_target) begin
      if ($urandom_range(0, 99) == 0)
        gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_cmd(qmb_pkg::cmd_code_t'($urandom_range(0, 3)), rand_tag(), rand_payload(),
                 st);
        done_count += (st == qmb_pkg::ST_DONE);
      end else if (pick < 55) begin
        send_cmd(qmb_pkg::CMD_PUSH, rand_tag(), rand_payload(), st);
        done_count += (st == qmb_pkg::ST_DONE);
        send_cmd(qmb_pkg::CMD_PUMP, rand_tag(), rand_payload(), st);
        done_count += (st == qmb_pkg::ST_DONE);
        send_cmd(qmb_pkg::CMD_RECV, rand_tag(), rand_payload(), st);
        done_count += (st == qmb_pkg::ST_DONE);
      end else if (ring_fill() < $urandom_range(0, 64)) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          send_cmd(qmb_pkg::CMD_PUSH, rand_tag(), rand_payload(), st);
          done_count += (st == qmb_pkg::ST_DONE);
        end
      end else begin
        send_cmd(qmb_pkg::CMD_PUMP, rand_tag(), rand_payload(), st);
        done_count += (st == qmb_pkg::ST_DONE);
        send_cmd(qmb_pkg::CMD_RECV, rand_tag(), rand_payload(), st);
        done_count += (st == qmb_pkg::ST_DONE);
      end
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.command = qmb_pkg::CMD_PUSH;
    cmd_if.record_tag = '0;
    cmd_if.record_payload = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_commands();
    test_record_path();
    test_ring_full();
    test_random_traffic(640);

    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("queued_mailbox_seq_ack: match");
    end else begin
      $display("queued_mailbox_seq_ack: mismatch");
    end
    $finish;
  end

endmodule
